// ----- hw/rtl/hstf_pkg.sv -----
`default_nettype none

package hstf_pkg;

    // start code bytes plus the nal header byte
    localparam int HEADER_SKIP  = 5;
    localparam int MAX_ZERO_RUN = 32;
    localparam int POS_W        = $clog2(HEADER_SKIP + 1);
    localparam int RUN_W        = $clog2(MAX_ZERO_RUN + 1);

    localparam logic [4:0] NAL_MASK = 5'h1f;
    localparam logic [4:0] NAL_SPS  = 5'd7;
    localparam logic [3:0] CODE_SAT = 4'd15;

    typedef enum logic [2:0] {
        PH_PRE1,
        PH_SUF1,
        PH_PRE2,
        PH_SUF2,
        PH_DONE
    } phase_t;

    typedef enum logic [1:0] {
        FRAME_P = 2'd0,
        FRAME_B = 2'd1,
        FRAME_I = 2'd2
    } frame_t;

    // accum carries the suffix of the code being read; after the second code it holds that code's saturated value
    typedef struct packed {
        phase_t             phase;
        logic [RUN_W-1:0]   zero_run;
        logic [RUN_W-1:0]   suffix_left;
        logic [3:0]         accum;
    } parse_t;

    localparam parse_t PARSE_CLEAR = '{phase: PH_PRE1, zero_run: '0, suffix_left: '0,
                                       accum: '0};

    function automatic logic [3:0] ones_below(logic [RUN_W-1:0] run);
        logic [3:0] v;
        v = 4'((4'd1 << run[1:0]) - 4'd1);
        return v;
    endfunction

    function automatic parse_t code_finish(parse_t s);
        parse_t n;
        n = s;
        if (s.phase == PH_PRE1 || s.phase == PH_SUF1) begin
            n = PARSE_CLEAR;
            n.phase = PH_PRE2;
        end
        else begin
            if (s.zero_run >= RUN_W'(4)) begin
                n.accum = CODE_SAT;
            end
            else begin
                n.accum = 4'(ones_below(s.zero_run) + s.accum);
            end
            n.phase = PH_DONE;
        end
        return n;
    endfunction

    function automatic parse_t take_bit(parse_t s, logic bit_val, logic final_bit);
        parse_t n;
        n = s;
        case (s.phase)
            PH_PRE1, PH_PRE2:
            begin
                if (!bit_val && !final_bit && s.zero_run < RUN_W'(MAX_ZERO_RUN)) begin
                    n.zero_run = RUN_W'(s.zero_run + 1'b1);
                end
                else begin
                    n.suffix_left = s.zero_run;
                    n.accum = '0;
                    if (s.zero_run == '0) begin
                        n = code_finish(n);
                    end
                    else begin
                        n.phase = (s.phase == PH_PRE1) ? PH_SUF1 : PH_SUF2;
                    end
                end
            end
            PH_SUF1, PH_SUF2:
            begin
                n.accum = {s.accum[2:0], bit_val};
                if (n.suffix_left != '0) begin
                    n.suffix_left = RUN_W'(n.suffix_left - 1'b1);
                end
                if (n.suffix_left == '0) begin
                    n = code_finish(n);
                end
            end
            default:
            begin
                n = s;
            end
        endcase
        return n;
    endfunction

    // value of the second code as it stands at packet end, saturated
    function automatic logic [3:0] slice_value(parse_t s);
        logic [3:0] v;
        case (s.phase)
            PH_DONE:
            begin
                v = s.accum;
            end
            PH_SUF2:
            begin
                if (s.zero_run >= RUN_W'(4)) begin
                    v = CODE_SAT;
                end
                else begin
                    v = 4'(ones_below(s.zero_run) + 4'(s.accum << s.suffix_left[1:0]));
                end
            end
            default:
            begin
                v = 4'd0;
            end
        endcase
        return v;
    endfunction

    function automatic frame_t class_of(logic [3:0] code);
        frame_t c;
        case (code) inside
            4'd1, 4'd6:             c = FRAME_B;
            4'd2, 4'd7, 4'd4, 4'd9: c = FRAME_I;
            default:                c = FRAME_P;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/hstf_if.sv -----
`default_nettype none

interface hstf_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       first_byte;
    logic       last_byte;
    logic       is_video;

    modport source (output valid, output data_byte, output first_byte, output last_byte,
                    output is_video, input ready);
    modport sink (input valid, input data_byte, input first_byte, input last_byte,
                  input is_video, output ready);
endinterface

interface hstf_out_if;
    logic       valid;
    logic       ready;
    logic [3:0] slice_type_code;
    logic [1:0] frame_class;
    logic       keep_packet;
    logic       flush_queue;

    modport source (output valid, output slice_type_code, output frame_class,
                    output keep_packet, output flush_queue, input ready);
    modport sink (input valid, input slice_type_code, input frame_class,
                  input keep_packet, input flush_queue, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/h264_slice_type_filter.sv -----
`default_nettype none

// h264 b-slice filter; each transfer carries a packet byte
// stream  : packet bytes in order; first_byte marks the opening byte, last_byte the
//           closing one, is_video is looked at on the closing byte
// verdict : one item per packet, sent for the last byte only: saturated slice type,
//           frame class (p, b, i), keep flag (clear for a b slice) and flush flag
//           (set for a kept sequence parameter set packet)
// a byte passes through the input register, then the parse logic walks its eight bits
// in one pass and, for a last byte, the verdict register loads
// throughput is one byte per cycle; bytes that produce no verdict keep flowing while
// a verdict waits on a stalled receiver, a last byte holds in the input register
// until the verdict register is free
// reset clears both valid flags and the parse state, so the first byte after reset
// starts a new packet whether or not first_byte is set
module h264_slice_type_filter (
    input  wire logic   clk,
    input  wire logic   rst_n,
    hstf_in_if.sink     stream,
    hstf_out_if.source  verdict
);
    import hstf_pkg::*;

    // input register
    logic                   in_valid_reg;
    logic [7:0]             data_reg;
    logic                   first_reg;
    logic                   last_reg;
    logic                   video_reg;

    // packet state
    logic [POS_W-1:0]       pos_reg;
    logic [POS_W-1:0]       pos_next;
    logic [4:0]             nal_reg;
    logic [4:0]             nal_next;
    parse_t                 parse_reg;
    parse_t                 parse_next;

    // verdict register
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic [3:0]             code_reg;
    frame_t                 class_reg;
    logic                   keep_reg;
    logic                   flush_reg;

    logic                   out_free;
    logic                   consume;
    logic                   emit;
    logic [POS_W-1:0]       pos_work;
    logic [4:0]             nal_work;
    parse_t                 parse_work;
    logic [3:0]             code_calc;
    frame_t                 class_calc;
    logic [3:0]             code_res;
    frame_t                 class_res;
    logic                   keep_res;
    logic                   flush_res;

    // the verdict slot frees up in the same cycle the receiver takes it
    assign out_free = !out_valid_reg || verdict.ready;
    assign consume  = in_valid_reg && (!last_reg || out_free);
    assign emit     = consume && last_reg;
    assign stream.ready = !in_valid_reg || consume;

    // parse of the registered byte
    always_comb
    begin
        pos_work   = pos_reg;
        nal_work   = nal_reg;
        parse_work = parse_reg;
        if (first_reg) begin
            pos_work   = '0;
            nal_work   = '0;
            parse_work = PARSE_CLEAR;
        end
        if (pos_work < POS_W'(HEADER_SKIP)) begin
            if (pos_work == POS_W'(HEADER_SKIP - 1)) begin
                nal_work = data_reg[4:0] & NAL_MASK;
            end
            pos_work = POS_W'(pos_work + 1'b1);
        end
        else begin
            // msb first; only the very last bit of the packet is marked final
            for (int b = 0; b < 8; b++) begin
                parse_work = take_bit(parse_work, data_reg[3'(7 - b)],
                                      last_reg && (b == 7));
            end
        end
    end

    // verdict fields
    always_comb
    begin
        code_calc  = slice_value(parse_work);
        class_calc = class_of(code_calc);
        if (video_reg) begin
            code_res  = code_calc;
            class_res = class_calc;
            keep_res  = (class_calc != FRAME_B);
            flush_res = (class_calc != FRAME_B) && (nal_work == NAL_SPS);
        end
        else begin
            // other media always passes untouched
            code_res  = 4'd0;
            class_res = FRAME_P;
            keep_res  = 1'b1;
            flush_res = 1'b0;
        end
    end

    // state update; a finished packet returns everything to the cleared state
    always_comb
    begin
        pos_next   = pos_reg;
        nal_next   = nal_reg;
        parse_next = parse_reg;
        if (consume) begin
            if (last_reg) begin
                pos_next   = '0;
                nal_next   = '0;
                parse_next = PARSE_CLEAR;
            end
            else begin
                pos_next   = pos_work;
                nal_next   = nal_work;
                parse_next = parse_work;
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit) begin
            out_valid_next = 1'b1;
        end
        else if (verdict.ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            pos_reg       <= '0;
            nal_reg       <= '0;
            parse_reg     <= PARSE_CLEAR;
        end
        else begin
            if (stream.ready) begin
                in_valid_reg <= stream.valid;
            end
            out_valid_reg <= out_valid_next;
            pos_reg       <= pos_next;
            nal_reg       <= nal_next;
            parse_reg     <= parse_next;
        end
    end

    // payload registers carry no reset
    always_ff @(posedge clk)
    begin
        if (stream.ready && stream.valid) begin
            data_reg  <= stream.data_byte;
            first_reg <= stream.first_byte;
            last_reg  <= stream.last_byte;
            video_reg <= stream.is_video;
        end
        if (emit) begin
            code_reg  <= code_res;
            class_reg <= class_res;
            keep_reg  <= keep_res;
            flush_reg <= flush_res;
        end
    end

    assign verdict.valid           = out_valid_reg;
    assign verdict.slice_type_code = code_reg;
    assign verdict.frame_class     = class_reg;
    assign verdict.keep_packet     = keep_reg;
    assign verdict.flush_queue     = flush_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/hstf_checker.sv -----
`default_nettype none

module hstf_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [3:0]  slice_type_code,
    input wire logic [1:0]  frame_class,
    input wire logic        keep_packet,
    input wire logic        flush_queue
);
    import hstf_pkg::*;

    // a waiting verdict stays until taken
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("verdict withdrawn while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(slice_type_code) && $stable(frame_class)
                                    && $stable(keep_packet) && $stable(flush_queue))
        else $error("verdict changed while stalled");

    // only a b slice is dropped
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> keep_packet == (frame_class != FRAME_B))
        else $error("keep flag disagrees with frame class");

    // a flush never comes with a drop
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && flush_queue |-> keep_packet)
        else $error("flush on a dropped packet");

    // class follows the code table for codes 0 and 10 and above, which map to p
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (slice_type_code == 4'd0 || slice_type_code >= 4'd10)
            |-> frame_class == FRAME_P)
        else $error("class wrong for a p code");

endmodule

bind h264_slice_type_filter hstf_checker u_hstf_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .out_valid       (verdict.valid),
    .out_ready       (verdict.ready),
    .slice_type_code (verdict.slice_type_code),
    .frame_class     (verdict.frame_class),
    .keep_packet     (verdict.keep_packet),
    .flush_queue     (verdict.flush_queue)
);

`default_nettype wire
